// ===== src/slcp_pkg.sv =====
`default_nettype none
package slcp_pkg;

    localparam int SLCP_MAX_DEVICES = 8;
    localparam int SLCP_QUEUE_DEPTH = 2;
    localparam int SLCP_BANK_DEPTH  = 8;

    localparam logic [1:0] REG_DEVICE_COUNT = 2'd0;
    localparam logic [1:0] REG_DEVICE_TYPES = 2'd1;
    localparam logic [1:0] REG_LOOP_OFFSET  = 2'd2;
    localparam logic [1:0] REG_REPEAT_COUNT = 2'd3;

    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_WAIT    = 3'd1;
    localparam logic [2:0] KIND_RESTART = 3'd2;
    localparam logic [2:0] KIND_SEEK    = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [1:0] CHIP_TYPE4 = 2'd0;
    localparam logic [1:0] CHIP_TYPE2 = 2'd1;
    localparam logic [1:0] CHIP_TYPE5 = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_DEVICE   = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] stream_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  chip_kind;
        logic [2:0]  instance_res;
        logic [8:0]  reg_address;
        logic [7:0]  reg_data;
        logic [31:0] wait_ticks;
        logic [31:0] seek_offset;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    prim_valid;
        result_t prim;
        logic    restart;
        logic    overflow;
    } rec_t;

endpackage
`default_nettype wire

// ===== src/sound_log_command_parser_unit.sv =====
`default_nettype none
// Channel  Handshake               Payload
// item     item_valid/item_ready   item (action, stream_byte, final_byte)
// res      res_valid/res_ready     res (one result word, last marks end of byte)
// cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One byte word is parsed per cycle while item_ready is high; results are queued for res.
// A byte yields up to three result words; the back end sends one per cycle unless stalled.
// A two-entry queue holds parsed bytes; item_ready drops only while it is full.
// Reset clears parse state, configuration and bank tracking at once; no clearing pass.
// cfg_ready is always high; write configuration only while the block is idle.
module sound_log_command_parser_unit
    import slcp_pkg::*;
#(
    parameter int MAX_DEVICES = SLCP_MAX_DEVICES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        item_valid,
    output      logic        item_ready,
    input  wire item_t       item,
    output      logic        res_valid,
    input  wire logic        res_ready,
    output      result_t     res
);

    logic rec_push;
    rec_t rec;
    logic queue_full;
    logic pop;
    logic head_valid;
    rec_t head_rec;

    slcp_front #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    slcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_rec   (rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    slcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
`default_nettype wire

// ===== src/slcp_front.sv =====
`default_nettype none
module slcp_front
    import slcp_pkg::*;
#(
    parameter int MAX_DEVICES = SLCP_MAX_DEVICES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        item_valid,
    output      logic        item_ready,
    input  wire item_t       item,
    input  wire logic        queue_full,
    output      logic        rec_push,
    output      rec_t        rec
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_ADDR = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    localparam logic [7:0] CMD_WAIT1 = 8'hff;
    localparam logic [7:0] CMD_WAITN = 8'hfe;
    localparam logic [7:0] CMD_END   = 8'hfd;

    localparam logic [3:0] DEV_TYPE2 = 4'd2;
    localparam logic [3:0] DEV_TYPE4 = 4'd4;
    localparam logic [3:0] DEV_TYPE5 = 4'd5;

    logic [3:0]  dcount_reg;
    logic [31:0] dtypes_reg;
    logic [31:0] loop_reg;
    logic [15:0] rcount_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  addr_reg, addr_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic [15:0] rleft_reg, rleft_next;
    logic        playing_reg, playing_next;
    logic [1:0]  bank_reg [SLCP_BANK_DEPTH];

    logic        accept;
    logic        moved;
    logic        bank_we;
    logic [1:0]  bank_wdata;
    logic [7:0]  b;
    logic [34:0] part;
    logic [34:0] shifted;
    logic [31:0] acc_upd;
    logic [32:0] ticks_sum;
    logic [6:0]  dev;
    logic        ext;
    logic [3:0]  cnt;
    logic [3:0]  dtype;
    logic [2:0]  inst;
    logic [1:0]  bank_now;

    assign cfg_ready  = 1'b1;
    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign b          = item.stream_byte;

    assign part    = {28'd0, b[6:0]};
    assign shifted = part << shift_reg;

    always_comb
    begin
        acc_upd = acc_reg;
        if (part != 35'd0)
        begin
            if (shift_reg >= 6'd32 || shifted[34:32] != 3'd0)
                acc_upd = '1;
            else
                acc_upd = acc_reg | shifted[31:0];
        end
    end

    assign ticks_sum = {1'b0, acc_upd} + 33'd2;

    assign dev = cmd_reg[7:1];
    assign ext = cmd_reg[0];
    assign cnt = (dcount_reg > 4'(MAX_DEVICES)) ? 4'(MAX_DEVICES) : dcount_reg;

    always_comb
    begin
        dtype = DEV_TYPE4;
        inst  = 3'd0;
        if (cnt != 4'd0)
        begin
            dtype = dtypes_reg[4 * dev[2:0] +: 4];
            for (int i = 0; i < MAX_DEVICES; i++)
            begin
                if (7'(i) < dev && dtypes_reg[4 * i +: 4] == dtype)
                    inst = inst + 3'd1;
            end
        end
    end

    assign bank_now = (addr_reg == 8'd0) ? b[6:5] : bank_reg[inst];

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        acc_next     = acc_reg;
        shift_next   = shift_reg;
        rleft_next   = rleft_reg;
        playing_next = playing_reg;
        bank_we      = 1'b0;
        bank_wdata   = b[6:5];
        moved        = 1'b0;
        rec          = '0;

        if (accept)
        begin
            if (item.action)
            begin
                playing_next = 1'b1;
                rleft_next   = rcount_reg;
                phase_next   = PH_CMD;
                cmd_next     = 8'd0;
                addr_next    = 8'd0;
                acc_next     = 32'd0;
                shift_next   = 6'd0;
            end
            else if (playing_reg)
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (b == CMD_WAIT1)
                        begin
                            rec.prim_valid      = 1'b1;
                            rec.prim.kind       = KIND_WAIT;
                            rec.prim.wait_ticks = 32'd1;
                        end
                        else if (b == CMD_WAITN)
                        begin
                            acc_next   = 32'd0;
                            shift_next = 6'd0;
                            phase_next = PH_WAIT;
                        end
                        else if (b == CMD_END)
                        begin
                            moved          = 1'b1;
                            rec.prim_valid = 1'b1;
                            if (loop_reg == 32'd0
                                || (rcount_reg != 16'd0 && rleft_reg <= 16'd1))
                            begin
                                if (rleft_reg != 16'd0 && loop_reg != 32'd0)
                                    rleft_next = rleft_reg - 16'd1;
                                playing_next  = 1'b0;
                                rec.prim.kind = KIND_END;
                            end
                            else
                            begin
                                if (rcount_reg != 16'd0)
                                    rleft_next = rleft_reg - 16'd1;
                                rec.prim.kind        = KIND_SEEK;
                                rec.prim.seek_offset = loop_reg;
                            end
                        end
                        else
                        begin
                            cmd_next   = b;
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_WAIT:
                    begin
                        acc_next = acc_upd;
                        if (shift_reg < 6'd32)
                            shift_next = shift_reg + 6'd7;
                        if (!b[7])
                        begin
                            rec.prim_valid      = 1'b1;
                            rec.prim.kind       = KIND_WAIT;
                            rec.prim.wait_ticks = ticks_sum[32] ? '1 : ticks_sum[31:0];
                            phase_next          = PH_CMD;
                        end
                    end
                    PH_ADDR:
                    begin
                        addr_next  = b;
                        phase_next = PH_DATA;
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                        if (cnt != 4'd0 && dev >= {3'd0, cnt})
                        begin
                            rec.prim_valid      = 1'b1;
                            rec.prim.kind       = KIND_ERROR;
                            rec.prim.error_code = ERR_DEVICE;
                            playing_next        = 1'b0;
                            moved               = 1'b1;
                        end
                        else if (dtype == DEV_TYPE4)
                        begin
                            rec.prim_valid        = 1'b1;
                            rec.prim.kind         = KIND_WRITE;
                            rec.prim.chip_kind    = CHIP_TYPE4;
                            rec.prim.instance_res = inst;
                            rec.prim.reg_address  = {ext, addr_reg};
                            rec.prim.reg_data     = b;
                            if (ext)
                            begin
                                bank_we     = (addr_reg == 8'd0);
                                rec.restart = (bank_now == 2'b11);
                            end
                        end
                        else if ((dtype == DEV_TYPE2 || dtype == DEV_TYPE5) && !ext)
                        begin
                            rec.prim_valid        = 1'b1;
                            rec.prim.kind         = KIND_WRITE;
                            rec.prim.chip_kind    = (dtype == DEV_TYPE2) ? CHIP_TYPE2
                                                                         : CHIP_TYPE5;
                            rec.prim.instance_res = inst;
                            rec.prim.reg_address  = {1'b0, addr_reg};
                            rec.prim.reg_data     = b;
                        end
                    end
                endcase

                if (item.final_byte && !moved)
                begin
                    rec.overflow = 1'b1;
                    playing_next = 1'b0;
                    phase_next   = PH_CMD;
                end
            end
        end
    end

    assign rec_push = rec.prim_valid || rec.restart || rec.overflow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcount_reg  <= 4'd0;
            dtypes_reg  <= 32'd0;
            loop_reg    <= 32'd0;
            rcount_reg  <= 16'd0;
            phase_reg   <= PH_CMD;
            cmd_reg     <= 8'd0;
            addr_reg    <= 8'd0;
            acc_reg     <= 32'd0;
            shift_reg   <= 6'd0;
            rleft_reg   <= 16'd0;
            playing_reg <= 1'b0;
            for (int i = 0; i < SLCP_BANK_DEPTH; i++)
            begin
                bank_reg[i] <= 2'd0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DEVICE_COUNT: dcount_reg <= cfg_data[3:0];
                    REG_DEVICE_TYPES: dtypes_reg <= cfg_data;
                    REG_LOOP_OFFSET:  loop_reg   <= cfg_data;
                    REG_REPEAT_COUNT: rcount_reg <= cfg_data[15:0];
                    default:          dcount_reg <= dcount_reg;
                endcase
            end
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            acc_reg     <= acc_next;
            shift_reg   <= shift_next;
            rleft_reg   <= rleft_next;
            playing_reg <= playing_next;
            if (bank_we)
                bank_reg[inst] <= bank_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== src/slcp_queue.sv =====
`default_nettype none
module slcp_queue
    import slcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire rec_t push_rec,
    output      logic full,
    input  wire logic pop,
    output      logic head_valid,
    output      rec_t head_rec
);

    localparam int PW = $clog2(SLCP_QUEUE_DEPTH);
    localparam int CW = $clog2(SLCP_QUEUE_DEPTH + 1);

    rec_t          q_reg [SLCP_QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(SLCP_QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = q_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PW'(SLCP_QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(SLCP_QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_rec;
    end

endmodule
`default_nettype wire

// ===== src/slcp_back.sv =====
`default_nettype none
module slcp_back
    import slcp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    head_valid,
    input  wire rec_t    head_rec,
    output      logic    pop,
    output      logic    res_valid,
    input  wire logic    res_ready,
    output      result_t res
);

    logic [2:0] done_reg, done_next;
    logic       valid_reg, valid_next;
    result_t    res_reg, res_next;
    logic [2:0] pend;
    logic [2:0] sel;
    logic       take;
    logic       load;
    logic       last;

    assign pend = {head_rec.overflow, head_rec.restart, head_rec.prim_valid} & ~done_reg;
    assign sel  = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : 3'b100);
    assign last = ((pend & ~sel) == 3'b000);
    assign take = !valid_reg || res_ready;
    assign load = take && head_valid && (pend != 3'b000);
    assign pop  = load && last;

    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            done_next  = last ? 3'b000 : (done_reg | sel);
            res_next   = '0;
            if (sel[0])
                res_next = head_rec.prim;
            else if (sel[1])
                res_next.kind = KIND_RESTART;
            else
            begin
                res_next.kind       = KIND_ERROR;
                res_next.error_code = ERR_OVERFLOW;
            end
            res_next.last = last;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 3'b000;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
`default_nettype wire
